// File: hdl/assert_macros.svh
// assertion macros shared by the circular list rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CLC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CLC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/clc_pkg.sv
// package for the circular list with cursor: operation codes and result type
// no dependencies
`default_nettype none

package clc_pkg;

  // width of the data fields on the channels
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_REMOVE  = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  typedef struct packed {
    logic [DATA_W-1:0] front_word;
    logic [DATA_W-1:0] back_word;
    logic              is_empty;
    logic              is_full;
    logic              fault;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/clc_if.sv
// channel interfaces of the circular list: operation items in, results out
// depends on clc_pkg
`default_nettype none

interface clc_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [clc_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface clc_out_if;
  logic                       valid;
  logic                       ready;
  logic [clc_pkg::DATA_W-1:0] front_word;
  logic [clc_pkg::DATA_W-1:0] back_word;
  logic                       is_empty;
  logic                       is_full;
  logic                       fault;

  modport source (output valid, output front_word, output back_word, output is_empty,
                  output is_full, output fault, input ready);
  modport sink (input valid, input front_word, input back_word, input is_empty,
                input is_full, input fault, output ready);
endinterface

`default_nettype wire

// File: hdl/clc_store.sv
// element store of the circular list: one write port, one registered read port
// read returns the word being written in the same cycle when the addresses match
`default_nettype none

module clc_store #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32,
  localparam int PTR_W    = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [PTR_W-1:0]     wr_addr_i,
  input  wire logic [WORD_BITS-1:0] wr_data_i,
  input  wire logic [PTR_W-1:0]     rd_addr_i,
  output logic      [WORD_BITS-1:0] rd_data_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port with write-through on a matching address
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// File: hdl/clc_engine.sv
// input register and list state of the circular list: pointer, count,
// front and back words, and the next-state logic for one item per cycle while the result register is free
// depends on clc_pkg, clc_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module clc_engine #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32,
  localparam int PTR_W    = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  clc_in_if.sink                    in_i,
  input  wire logic                 out_free_i,
  output logic                      load_o,
  output clc_pkg::res_t             res_o,
  output logic                      wr_en_o,
  output logic      [PTR_W-1:0]     wr_addr_o,
  output logic      [WORD_BITS-1:0] wr_data_o,
  output logic      [PTR_W-1:0]     rd_addr_o,
  input  wire logic [WORD_BITS-1:0] rd_data_i
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (WORD_BITS < clc_pkg::DATA_W) ? WORD_BITS : clc_pkg::DATA_W;

  // wrapped increment of a store index
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // stored word to port width
  function automatic logic [clc_pkg::DATA_W-1:0] to_port(input logic [WORD_BITS-1:0] w);
    logic [clc_pkg::DATA_W-1:0] r;
    r = '0;
    r[CW-1:0] = w[CW-1:0];
    return r;
  endfunction

  logic                  in_valid_q;
  clc_pkg::func_e        func_q;
  logic [clc_pkg::DATA_W-1:0] value_q;
  logic                  fire;

  logic [PTR_W-1:0]      fp_q, fp_d, fp_dec, fp_inc, past_back;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [WORD_BITS-1:0]  front_q, front_d, back_q, back_d, word_in;
  logic [CNT_W:0]        pb_sum, pb_wrap;
  logic                  cnt_zero, cnt_full, cnt_one, fault;
  logic                  empty_d;

  // input register: takes an item whenever it is empty or being drained
  assign fire       = in_valid_q && out_free_i;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q  <= clc_pkg::func_e'(in_i.func);
      value_q <= in_i.value;
    end
  end

  // neighbor indexes of the ring
  assign cnt_zero = (cnt_q == '0);
  assign cnt_full = (cnt_q == CNT_W'(DEPTH));
  assign cnt_one  = (cnt_q == CNT_W'(1));
  assign fp_dec   = (fp_q == '0) ? PTR_W'(DEPTH - 1) : fp_q - PTR_W'(1);
  assign fp_inc   = ptr_inc(fp_q);
  assign pb_sum   = (CNT_W + 1)'(fp_q) + (CNT_W + 1)'(cnt_q);
  assign pb_wrap  = (pb_sum >= (CNT_W + 1)'(DEPTH)) ? pb_sum - (CNT_W + 1)'(DEPTH) : pb_sum;
  assign past_back = pb_wrap[PTR_W-1:0];

  // data word held to the stored width
  always_comb begin
    word_in = '0;
    word_in[CW-1:0] = value_q[CW-1:0];
  end

  // next state for the item in the input register
  always_comb begin
    fp_d      = fp_q;
    cnt_d     = cnt_q;
    front_d   = front_q;
    back_d    = back_q;
    fault     = 1'b0;
    wr_en_o   = 1'b0;
    wr_addr_o = fp_dec;
    wr_data_o = word_in;
    if (fire) begin
      case (func_q)
        clc_pkg::FUNC_INSERT: begin
          if (cnt_full) begin
            fault = 1'b1;
          end else begin
            fp_d    = fp_dec;
            cnt_d   = cnt_q + CNT_W'(1);
            front_d = word_in;
            wr_en_o = 1'b1;
            if (cnt_zero) begin
              back_d = word_in;
            end
          end
        end
        clc_pkg::FUNC_REMOVE: begin
          if (cnt_zero) begin
            fault = 1'b1;
          end else begin
            fp_d    = fp_inc;
            cnt_d   = cnt_q - CNT_W'(1);
            front_d = rd_data_i;
          end
        end
        clc_pkg::FUNC_ADVANCE: begin
          if (cnt_zero) begin
            fault = 1'b1;
          end else begin
            fp_d      = fp_inc;
            wr_en_o   = 1'b1;
            wr_addr_o = past_back;
            wr_data_o = front_q;
            if (!cnt_one) begin
              front_d = rd_data_i;
              back_d  = front_q;
            end
          end
        end
        clc_pkg::FUNC_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  // prefetch the entry after the front of the next state
  assign rd_addr_o = ptr_inc(fp_d);

  // list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q  <= '0;
      cnt_q <= '0;
    end else begin
      fp_q  <= fp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
  end

  // result of the item
  assign empty_d = (cnt_d == '0);
  assign load_o  = fire;

  always_comb begin
    res_o.front_word = empty_d ? '0 : to_port(front_d);
    res_o.back_word  = empty_d ? '0 : to_port(back_d);
    res_o.is_empty   = empty_d;
    res_o.is_full    = (cnt_d == CNT_W'(DEPTH));
    res_o.fault      = fault;
  end

  `CLC_ASSERT(a_cnt_range, cnt_q <= CNT_W'(DEPTH), "element count beyond depth")
  `CLC_ASSERT(a_ptr_range, fp_q <= PTR_W'(DEPTH - 1), "front pointer outside store")
  `CLC_ASSERT_NEXT(a_fault_hold, fire && fault, $stable(cnt_q) && $stable(fp_q), "refused item changed list")

endmodule

`default_nettype wire

// File: hdl/clc_out_reg.sv
// result register of the circular list, drives the output channel
// depends on clc_pkg, clc_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module clc_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  clc_pkg::res_t      res_i,
  output logic               out_free_o,
  clc_out_if.source          out_o
);

  logic          valid_q;
  clc_pkg::res_t res_q;

  // free when empty or being taken this cycle
  assign out_free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  // channel drive
  assign out_o.valid      = valid_q;
  assign out_o.front_word = res_q.front_word;
  assign out_o.back_word  = res_q.back_word;
  assign out_o.is_empty   = res_q.is_empty;
  assign out_o.is_full    = res_q.is_full;
  assign out_o.fault      = res_q.fault;

  `CLC_ASSERT(a_no_overwrite, !load_i || !valid_q || out_o.ready, "result overwritten before taken")

endmodule

`default_nettype wire

// File: hdl/circular_list_with_cursor_top.sv
// Circular list with cursor: a bounded ring of DEPTH data words.
// The back element sits at the cursor, the front element follows it.
// in_i carries one operation per item (func: insert at front, remove front,
// advance cursor, read only; value: word to insert). out_o carries one
// result per item: front and back words after the operation (zero when empty),
// empty and full flags, and a fault flag for a refused operation (remove or
// advance on an empty list, insert into a full one); a refused item leaves
// the list as it was.
// Throughput: one item per cycle while the receiver takes results. The state
// update of an item and the prefetch of the entry after the new front complete
// together, through one write port and one registered read port on the store.
// An accepted item is held in the input register, then its result is registered.
// Reset empties the list at once (pointer and count cleared); no clearing
// pass runs over the store. A stalled receiver holds the result register;
// one more item is still taken into the input register, then in_i.ready drops.
// depends on clc_pkg, clc_if, clc_store, clc_engine, clc_out_reg
`default_nettype none

module circular_list_with_cursor_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clc_in_if.sink    in_i,
  clc_out_if.source out_o
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                 out_free;
  logic                 load;
  clc_pkg::res_t        res;
  logic                 wr_en;
  logic [PTR_W-1:0]     wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  // list state and next-state logic
  clc_engine #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .load_o     (load),
    .res_o      (res),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  // element store
  clc_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // result register
  clc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .res_i      (res),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
